// ===== hdl/hlr_pkg.sv =====
package hlr_pkg;

  localparam int MAX_ROWS  = 32;
  localparam int MAX_COLS  = 32;
  localparam int DATA_BITS = 32;
  localparam int FRAC_BITS = 16;

  localparam int ROW_AW = $clog2(MAX_ROWS);
  localparam int COL_AW = $clog2(MAX_COLS);
  localparam int MAT_AW = ROW_AW + COL_AW;

  localparam int ACTION_W    = 2;
  localparam int POS_W       = 5;
  localparam int CFG_W       = 6;
  localparam int CFG_INDEX_W = 2;

  localparam int PROD_W = 2 * DATA_BITS;
  localparam int RND_W  = 2 * DATA_BITS - FRAC_BITS + 1;
  localparam int SUM_W  = RND_W + 1;

  typedef logic signed [DATA_BITS-1:0] word_t;

  localparam word_t DATA_MAX = {1'b0, {(DATA_BITS-1){1'b1}}};
  localparam word_t DATA_MIN = {1'b1, {(DATA_BITS-1){1'b0}}};

  localparam logic [ACTION_W-1:0] ACT_WRITE_MATRIX = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WRITE_VECTOR = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_APPLY        = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_READ         = 2'd3;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_ROWS_IN_USE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLS_IN_USE = 2'd1;

  localparam logic [CFG_W-1:0] ROWS_RESET = 6'd32;
  localparam logic [CFG_W-1:0] COLS_RESET = 6'd32;

  typedef struct packed {
    logic              update;
    logic              first;
    logic [COL_AW-1:0] col;
    logic [MAT_AW-1:0] addr;
  } tag_t;

  typedef struct packed {
    logic              en;
    logic              update;
    logic              clip;
    logic [COL_AW-1:0] col;
    logic [MAT_AW-1:0] addr;
    word_t             value;
  } wb_t;

endpackage

// ===== hdl/hlr_item_if.sv =====
interface hlr_item_if;
  import hlr_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [POS_W-1:0]    row;
  logic [POS_W-1:0]    column;
  logic [POS_W-1:0]    vector_index;
  word_t               value;
  logic [POS_W-1:0]    step;

  modport source (
    output valid, action, row, column, vector_index, value, step,
    input  ready
  );

  modport sink (
    input  valid, action, row, column, vector_index, value, step,
    output ready
  );
endinterface

// ===== hdl/hlr_result_if.sv =====
interface hlr_result_if;
  import hlr_pkg::*;

  logic  valid;
  logic  ready;
  logic  kind;
  word_t data;
  logic  saturated;

  modport source (
    output valid, kind, data, saturated,
    input  ready
  );

  modport sink (
    input  valid, kind, data, saturated,
    output ready
  );
endinterface

// ===== hdl/hlr_cfg_if.sv =====
interface hlr_cfg_if;
  import hlr_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_W-1:0]       data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ===== hdl/hlr_stores.sv =====
module hlr_stores (
  input  logic                       clk,
  input  logic                       mat_we,
  input  logic [hlr_pkg::MAT_AW-1:0] mat_waddr,
  input  hlr_pkg::word_t             mat_wdata,
  input  logic                       mat_re,
  input  logic [hlr_pkg::MAT_AW-1:0] mat_raddr,
  output hlr_pkg::word_t             mat_rdata,
  input  logic                       vec_we,
  input  logic [hlr_pkg::ROW_AW-1:0] vec_waddr,
  input  hlr_pkg::word_t             vec_wdata,
  input  logic                       vec_re,
  input  logic [hlr_pkg::ROW_AW-1:0] vec_raddr,
  output hlr_pkg::word_t             vec_rdata,
  input  logic                       sum_we,
  input  logic [hlr_pkg::COL_AW-1:0] sum_waddr,
  input  hlr_pkg::word_t             sum_wdata,
  input  logic                       sum_re,
  input  logic [hlr_pkg::COL_AW-1:0] sum_raddr,
  output hlr_pkg::word_t             sum_rdata
);
  import hlr_pkg::*;

  word_t mat_mem [0:2**MAT_AW-1];
  word_t vec_mem [0:2**ROW_AW-1];
  word_t sum_mem [0:2**COL_AW-1];

  always_ff @(posedge clk) begin
    if (mat_we) mat_mem[mat_waddr] <= mat_wdata;
    if (mat_re) mat_rdata <= mat_mem[mat_raddr];
  end

  always_ff @(posedge clk) begin
    if (vec_we) vec_mem[vec_waddr] <= vec_wdata;
    if (vec_re) vec_rdata <= vec_mem[vec_raddr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    if (sum_re) sum_rdata <= sum_mem[sum_raddr];
  end
endmodule

// ===== hdl/hlr_mac.sv =====
module hlr_mac (
  input  logic           clk,
  input  logic           rst,
  input  logic           issue,
  input  hlr_pkg::tag_t  issue_tag,
  input  hlr_pkg::word_t mat_rd,
  input  hlr_pkg::word_t vec_rd,
  input  hlr_pkg::word_t sum_rd,
  output hlr_pkg::wb_t   wb,
  output logic           busy
);
  import hlr_pkg::*;

  localparam logic signed [PROD_W-1:0] HALF_ACC = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [PROD_W-1:0] HALF_UPD = PROD_W'(1) << (FRAC_BITS - 2);
  localparam logic signed [SUM_W-1:0]  SUM_MAX  = SUM_W'(DATA_MAX);
  localparam logic signed [SUM_W-1:0]  SUM_MIN  = SUM_W'(DATA_MIN);

  logic v1, v2, v3;
  tag_t tag1, tag2, tag3;

  word_t                     op_a;
  word_t                     old1;
  word_t                     old2;
  word_t                     old3;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  biased;
  logic signed [PROD_W-1:0]  shifted;
  logic signed [RND_W-1:0]   rnd_next;
  logic signed [RND_W-1:0]   rnd3;
  logic signed [SUM_W-1:0]   acc;

  always_comb begin
    op_a = tag1.update ? sum_rd : mat_rd;
    if (tag1.update) begin
      old1 = mat_rd;
    end else if (tag1.first) begin
      old1 = '0;
    end else begin
      old1 = sum_rd;
    end
  end

  always_comb begin
    biased   = prod + (tag2.update ? HALF_UPD : HALF_ACC);
    shifted  = tag2.update ? (biased >>> (FRAC_BITS - 1)) : (biased >>> FRAC_BITS);
    rnd_next = RND_W'(shifted);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    tag1 <= issue_tag;
    prod <= op_a * vec_rd;
    old2 <= old1;
    tag2 <= tag1;
    rnd3 <= rnd_next;
    old3 <= old2;
    tag3 <= tag2;
  end

  always_comb begin
    if (tag3.update) begin
      acc = SUM_W'(old3) - SUM_W'(rnd3);
    end else begin
      acc = SUM_W'(old3) + SUM_W'(rnd3);
    end
    wb.en     = v3;
    wb.update = tag3.update;
    wb.col    = tag3.col;
    wb.addr   = tag3.addr;
    if (acc > SUM_MAX) begin
      wb.value = DATA_MAX;
      wb.clip  = 1'b1;
    end else if (acc < SUM_MIN) begin
      wb.value = DATA_MIN;
      wb.clip  = 1'b1;
    end else begin
      wb.value = DATA_BITS'(acc);
      wb.clip  = 1'b0;
    end
  end

  assign busy = v1 | v2 | v3;
endmodule

// ===== hdl/householder_left_reflect_unit.sv =====
// Householder left reflection on a locally held Q16.16 matrix. Matrix and vector writes are
// accepted one per cycle while the unit is idle; a read returns its element in the cycle after
// the transfer, and writes keep flowing while that result waits. An apply item blocks further
// items until its finished result is posted: over n = min(rows_in_use, 32) - step active rows
// and m = min(cols_in_use, 32) columns it runs a column accumulation pass, a pipeline drain,
// an element update pass and a second drain. Both passes read through the single read port
// of the matrix memory, one element per cycle in the update pass; accumulation also waits on
// the read, multiply, round and write-back loop on a column sum, which spaces accumulations
// apart when fewer than four columns are in use. Column sums start fresh on the first active
// row of each apply, so no clearing pass runs after reset.
module householder_left_reflect_unit (
  input logic         clk,
  input logic         rst,
  hlr_item_if.sink    items,
  hlr_result_if.source results,
  hlr_cfg_if.sink     cfg
);
  import hlr_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PASS1  = 3'd1;
  localparam logic [2:0] ST_DRAIN1 = 3'd2;
  localparam logic [2:0] ST_PASS2  = 3'd3;
  localparam logic [2:0] ST_DRAIN2 = 3'd4;

  localparam int ACC_SPACING = 4;
  localparam int GAP_W       = 2;

  logic [2:0]       state;
  logic [CFG_W-1:0] rows_in_use;
  logic [CFG_W-1:0] cols_in_use;
  logic [CFG_W-1:0] nr_eff;
  logic [CFG_W-1:0] nc_eff;
  logic [CFG_W-1:0] r;
  logic [CFG_W-1:0] c;
  logic [POS_W-1:0] k;
  logic [GAP_W-1:0] gap;
  logic             clip_seen;
  logic             pending;
  logic             out_kind;
  logic             out_sat;
  logic             out_zero;

  logic              in_acc;
  logic              pos_ok;
  logic              vidx_ok;
  logic              issue;
  logic              last_col;
  logic              last_row;
  logic [MAT_AW-1:0] item_addr;
  tag_t              issue_tag;
  wb_t               wb;
  logic              busy;

  logic              mat_we;
  logic [MAT_AW-1:0] mat_waddr;
  word_t             mat_wdata;
  logic              mat_re;
  logic [MAT_AW-1:0] mat_raddr;
  word_t             mat_rdata;
  word_t             vec_rdata;
  word_t             sum_rdata;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= ROWS_RESET;
      cols_in_use <= COLS_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ROWS_IN_USE: rows_in_use <= cfg.data;
        REG_COLS_IN_USE: cols_in_use <= cfg.data;
        default: ;
      endcase
    end
  end

  assign nr_eff = (int'(rows_in_use) > MAX_ROWS) ? CFG_W'(MAX_ROWS) : rows_in_use;
  assign nc_eff = (int'(cols_in_use) > MAX_COLS) ? CFG_W'(MAX_COLS) : cols_in_use;

  assign items.ready = (state == ST_IDLE) &&
      (!pending || results.ready ||
       items.action inside {ACT_WRITE_MATRIX, ACT_WRITE_VECTOR});
  assign in_acc    = items.valid && items.ready;
  assign pos_ok    = (int'(items.row) < MAX_ROWS) && (int'(items.column) < MAX_COLS);
  assign vidx_ok   = int'(items.vector_index) < MAX_ROWS;
  assign item_addr = {ROW_AW'(items.row), COL_AW'(items.column)};

  assign issue    = (state == ST_PASS2) || ((state == ST_PASS1) && (gap == '0));
  assign last_col = (c + CFG_W'(1)) == nc_eff;
  assign last_row = (r + CFG_W'(1)) == nr_eff;

  always_comb begin
    issue_tag.update = (state == ST_PASS2);
    issue_tag.first  = (r == CFG_W'(k));
    issue_tag.col    = COL_AW'(c);
    issue_tag.addr   = {ROW_AW'(r), COL_AW'(c)};
  end

  always_comb begin
    if (wb.en && wb.update) begin
      mat_we    = 1'b1;
      mat_waddr = wb.addr;
      mat_wdata = wb.value;
    end else begin
      mat_we    = in_acc && (items.action == ACT_WRITE_MATRIX) && pos_ok;
      mat_waddr = item_addr;
      mat_wdata = items.value;
    end
    mat_re    = issue || (in_acc && (items.action == ACT_READ));
    mat_raddr = issue ? issue_tag.addr : item_addr;
  end

  hlr_stores u_stores (
    .clk       (clk),
    .mat_we    (mat_we),
    .mat_waddr (mat_waddr),
    .mat_wdata (mat_wdata),
    .mat_re    (mat_re),
    .mat_raddr (mat_raddr),
    .mat_rdata (mat_rdata),
    .vec_we    (in_acc && (items.action == ACT_WRITE_VECTOR) && vidx_ok),
    .vec_waddr (ROW_AW'(items.vector_index)),
    .vec_wdata (items.value),
    .vec_re    (issue),
    .vec_raddr (ROW_AW'(r - CFG_W'(k))),
    .vec_rdata (vec_rdata),
    .sum_we    (wb.en && !wb.update),
    .sum_waddr (wb.col),
    .sum_wdata (wb.value),
    .sum_re    (issue),
    .sum_raddr (COL_AW'(c)),
    .sum_rdata (sum_rdata)
  );

  hlr_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .issue_tag (issue_tag),
    .mat_rd    (mat_rdata),
    .vec_rd    (vec_rdata),
    .sum_rd    (sum_rdata),
    .wb        (wb),
    .busy      (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      r         <= '0;
      c         <= '0;
      k         <= '0;
      gap       <= '0;
      clip_seen <= 1'b0;
      pending   <= 1'b0;
      out_kind  <= KIND_READ;
      out_sat   <= 1'b0;
      out_zero  <= 1'b0;
    end else begin
      if (wb.en && wb.clip) clip_seen <= 1'b1;
      unique case (state)
        ST_IDLE: begin
          if (in_acc && (items.action == ACT_READ)) begin
            pending  <= 1'b1;
            out_kind <= KIND_READ;
            out_sat  <= 1'b0;
            out_zero <= !pos_ok;
          end else if (in_acc && (items.action == ACT_APPLY)) begin
            k         <= items.step;
            r         <= CFG_W'(items.step);
            c         <= '0;
            gap       <= '0;
            clip_seen <= 1'b0;
            if ((CFG_W'(items.step) >= nr_eff) || (nc_eff == '0)) begin
              pending  <= 1'b1;
              out_kind <= KIND_DONE;
              out_sat  <= 1'b0;
              out_zero <= 1'b0;
            end else begin
              state   <= ST_PASS1;
              pending <= 1'b0;
            end
          end else if (results.ready) begin
            pending <= 1'b0;
          end
        end
        ST_PASS1: begin
          if (issue) begin
            gap <= (int'(nc_eff) < ACC_SPACING) ? GAP_W'(ACC_SPACING - 1) : '0;
            if (last_col) begin
              c <= '0;
              if (last_row) state <= ST_DRAIN1;
              else r <= r + CFG_W'(1);
            end else begin
              c <= c + CFG_W'(1);
            end
          end else begin
            gap <= gap - GAP_W'(1);
          end
        end
        ST_DRAIN1: begin
          if (!busy) begin
            state <= ST_PASS2;
            r     <= CFG_W'(k);
            c     <= '0;
          end
        end
        ST_PASS2: begin
          if (last_col) begin
            c <= '0;
            if (last_row) state <= ST_DRAIN2;
            else r <= r + CFG_W'(1);
          end else begin
            c <= c + CFG_W'(1);
          end
        end
        ST_DRAIN2: begin
          if (!busy) begin
            state    <= ST_IDLE;
            pending  <= 1'b1;
            out_kind <= KIND_DONE;
            out_sat  <= clip_seen;
            out_zero <= 1'b0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign results.valid     = pending;
  assign results.kind      = out_kind;
  assign results.data      = ((out_kind == KIND_DONE) || out_zero) ? '0 : mat_rdata;
  assign results.saturated = out_sat;

  a_no_writeback_idle: assert property (@(posedge clk) disable iff (rst)
    wb.en |-> (state != ST_IDLE))
    else $error("write-back while idle");

  a_sums_settled_pass2: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PASS2) |-> !(wb.en && !wb.update))
    else $error("column sum write during update pass");

  a_done_after_drain: assert property (@(posedge clk) disable iff (rst)
    (results.valid && (results.kind == KIND_DONE)) |-> !busy)
    else $error("finished result with pipeline busy");

  a_single_read_port: assert property (@(posedge clk) disable iff (rst)
    issue |-> !in_acc)
    else $error("item transfer during reflection");
endmodule
